### design/smqr_pkg.sv
// ----------------------------------------------------------------------------
// smqr_pkg
// shared constants and types of the serial measurement query responder
// ----------------------------------------------------------------------------
package smqr_pkg;

	// command line
	localparam int CMD_LEN = 5;
	localparam int CNT_W   = 3;

	// measurement values
	localparam int VAL_W = 18;
	localparam int MAG_W = 17;
	localparam logic signed [VAL_W-1:0] VAL_LIMIT     = 18'sd99999;
	localparam logic signed [VAL_W-1:0] VAL_LIMIT_NEG = -18'sd99999;

	// reciprocal of 100, exact for every magnitude up to the limit
	localparam logic [17:0] DIV100_M = 18'd167773;
	localparam int          DIV100_S = 24;

	// reply
	localparam int REPLY_MAX = 11;
	localparam int LEN_W     = 4;

	// character codes
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_V     = 8'h76;
	localparam logic [7:0] CH_I     = 8'h69;
	localparam logic [7:0] CH_P     = 8'h70;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_ZERO  = 8'h30;

	typedef struct packed {
		logic [REPLY_MAX-1:0][7:0] chars;
		logic [LEN_W-1:0]          len;
	} reply_t;

endpackage

### design/smqr_tx.sv
// ----------------------------------------------------------------------------
// smqr_tx
// output shift register: loads a whole reply and sends it one character
// per cycle while out_stall is low, flagging the closing newline
// ----------------------------------------------------------------------------
module smqr_tx (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             ld_valid,
	input  smqr_pkg::reply_t ld_reply,
	output logic             ld_free,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [7:0]       tx_byte,
	output logic             last
);

	logic [smqr_pkg::REPLY_MAX-1:0][7:0] buf_q;
	logic [smqr_pkg::LEN_W-1:0]          rem_q;
	logic                                ld;
	logic                                out_acc;

	assign out_valid = (rem_q != '0);
	assign last      = (rem_q == smqr_pkg::LEN_W'(1));
	assign tx_byte   = buf_q[0];
	assign out_acc   = out_valid && !out_stall;

	// a new reply may load as the closing character leaves
	assign ld_free = (rem_q == '0) || (last && !out_stall);
	assign ld      = ld_valid && ld_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
		end else if (ld) begin
			rem_q <= ld_reply.len;
		end else if (out_acc) begin
			rem_q <= rem_q - smqr_pkg::LEN_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			buf_q <= ld_reply.chars;
		end else if (out_acc) begin
			buf_q <= {8'h00, buf_q[smqr_pkg::REPLY_MAX-1:1]};
		end
	end

	a_ld_len: assert property (@(posedge clk) disable iff (!arst_n)
		ld |-> (ld_reply.len != '0) &&
			(ld_reply.len <= smqr_pkg::LEN_W'(smqr_pkg::REPLY_MAX)))
		else $error("reply loaded with bad length");

	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		rem_q <= smqr_pkg::LEN_W'(smqr_pkg::REPLY_MAX))
		else $error("remaining count out of range");

	a_last_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(out_acc && last && !ld) |=> !out_valid)
		else $error("output still valid after closing item");

endmodule

### design/serial_measurement_query_responder.sv
// ----------------------------------------------------------------------------
// serial_measurement_query_responder
// answers serial measurement queries with an ascii decimal reply
// ----------------------------------------------------------------------------
// Every received byte is one input item. A byte other than carriage return
// gives no output; the fifth byte of a line is kept as the command letter.
// A carriage return passes three register stages (select and saturate,
// divide by 100, split into digits) and its reply of 1 to 11 characters is
// then sent from an output shift register at one character per cycle while
// out_stall is low, with last on the closing newline. Input is taken every
// cycle while the stages have room; the output shift register sets the
// sustained rate, so back-to-back carriage returns wait in the stages while
// an earlier reply is still being sent.
module serial_measurement_query_responder (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [7:0]                          rx_byte,
	input  logic signed [smqr_pkg::VAL_W-1:0]   volts_value,
	input  logic signed [smqr_pkg::VAL_W-1:0]   amps_value,
	input  logic signed [smqr_pkg::VAL_W-1:0]   power_value,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [7:0]                          tx_byte,
	output logic                                last
);

	// command line state
	logic [smqr_pkg::CNT_W-1:0] count_q;
	logic [7:0]                 letter_q;

	logic in_acc;
	logic is_cr;

	// value selection
	logic signed [smqr_pkg::VAL_W-1:0] sel_val;
	logic signed [smqr_pkg::VAL_W-1:0] sat_val;
	logic                              sel_has;
	logic [smqr_pkg::MAG_W-1:0]        sel_mag;

	// stage controls
	logic v_s1, v_s2, v_s3;
	logic en1, en2, en3;
	logic ld_free;

	// stage payloads
	logic                       neg_s1, has_s1;
	logic [smqr_pkg::MAG_W-1:0] mag_s1;
	logic                       neg_s2, has_s2;
	logic [smqr_pkg::MAG_W-1:0] mag_s2;
	logic [9:0]                 whole_s2;
	logic                       neg_s3, has_s3;
	logic [9:0]                 whole_s3;
	logic [6:0]                 frac_s3;
	logic [3:0]                 hund_s3;
	logic [6:0]                 wt_s3;

	logic [34:0]                prod_s1;

	// digit split and reply build
	logic [3:0]        d_t, d_o, f_t, f_o;
	logic [7:0][7:0]   tail;
	logic [1:0]        lead;
	smqr_pkg::reply_t  reply;

	assign in_acc   = in_valid && !in_stall;
	assign is_cr    = (rx_byte == smqr_pkg::CH_CR);

	assign en3      = !v_s3 || ld_free;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign in_stall = !en1;

	always_comb begin
		sel_val = volts_value;
		sel_has = 1'b1;
		priority if (letter_q == smqr_pkg::CH_V) begin
			sel_val = volts_value;
		end else if (letter_q == smqr_pkg::CH_I) begin
			sel_val = amps_value;
		end else if (letter_q == smqr_pkg::CH_P) begin
			sel_val = power_value;
		end else begin
			sel_has = 1'b0;
		end
	end

	always_comb begin
		if (sel_val > smqr_pkg::VAL_LIMIT) begin
			sat_val = smqr_pkg::VAL_LIMIT;
		end else if (sel_val < smqr_pkg::VAL_LIMIT_NEG) begin
			sat_val = smqr_pkg::VAL_LIMIT_NEG;
		end else begin
			sat_val = sel_val;
		end
	end

	assign sel_mag = sat_val[smqr_pkg::VAL_W-1] ? smqr_pkg::MAG_W'(-sat_val)
		: smqr_pkg::MAG_W'(sat_val);

	// command line tracking and stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			letter_q <= '0;
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			v_s3     <= 1'b0;
		end else begin
			if (in_acc) begin
				if (is_cr) begin
					count_q  <= '0;
					letter_q <= '0;
				end else if (count_q < smqr_pkg::CNT_W'(smqr_pkg::CMD_LEN)) begin
					if (count_q == smqr_pkg::CNT_W'(smqr_pkg::CMD_LEN - 1)) begin
						letter_q <= rx_byte;
					end
					count_q <= count_q + smqr_pkg::CNT_W'(1);
				end
			end
			if (en1) begin
				v_s1 <= in_acc && is_cr;
			end
			if (en2) begin
				v_s2 <= v_s1;
			end
			if (en3) begin
				v_s3 <= v_s2;
			end
		end
	end

	assign prod_s1 = 35'(mag_s1) * 35'(smqr_pkg::DIV100_M);

	always_ff @(posedge clk) begin
		if (en1) begin
			neg_s1 <= sat_val[smqr_pkg::VAL_W-1];
			has_s1 <= sel_has;
			mag_s1 <= sel_mag;
		end
		if (en2) begin
			neg_s2   <= neg_s1;
			has_s2   <= has_s1;
			mag_s2   <= mag_s1;
			whole_s2 <= 10'(prod_s1 >> smqr_pkg::DIV100_S);
		end
		if (en3) begin
			neg_s3   <= neg_s2;
			has_s3   <= has_s2;
			whole_s3 <= whole_s2;
			frac_s3  <= 7'(mag_s2 - 17'(whole_s2) * 17'd100);
			hund_s3  <= 4'((16'(whole_s2) * 16'd41) >> 12);
			wt_s3    <= 7'((18'(whole_s2) * 18'd205) >> 11);
		end
	end

	assign d_t = 4'(wt_s3 - 7'(hund_s3) * 7'd10);
	assign d_o = 4'(whole_s3 - 10'(wt_s3) * 10'd10);
	assign f_t = 4'((15'(frac_s3) * 15'd205) >> 11);
	assign f_o = 4'(frac_s3 - 7'(f_t) * 7'd10);

	// ones digit onward; always present in a value reply
	assign tail[0] = smqr_pkg::CH_ZERO + 8'(d_o);
	assign tail[1] = smqr_pkg::CH_DOT;
	assign tail[2] = smqr_pkg::CH_ZERO + 8'(f_t);
	assign tail[3] = smqr_pkg::CH_ZERO + 8'(f_o);
	assign tail[4] = smqr_pkg::CH_SPACE;
	assign tail[5] = smqr_pkg::CH_SPACE;
	assign tail[6] = smqr_pkg::CH_SPACE;
	assign tail[7] = smqr_pkg::CH_NL;

	always_comb begin
		lead = '0;
		for (int j = 0; j < smqr_pkg::REPLY_MAX; j++) begin
			reply.chars[4'(j)] = smqr_pkg::CH_NL;
		end
		reply.len = smqr_pkg::LEN_W'(1);
		if (has_s3) begin
			if (neg_s3) begin
				reply.chars[4'(lead)] = smqr_pkg::CH_MINUS;
				lead = lead + 2'd1;
			end
			if (whole_s3 >= 10'd100) begin
				reply.chars[4'(lead)] = smqr_pkg::CH_ZERO + 8'(hund_s3);
				lead = lead + 2'd1;
			end
			if (whole_s3 >= 10'd10) begin
				reply.chars[4'(lead)] = smqr_pkg::CH_ZERO + 8'(d_t);
				lead = lead + 2'd1;
			end
			for (int j = 0; j < 8; j++) begin
				reply.chars[4'(lead) + 4'(j)] = tail[3'(j)];
			end
			reply.len = 4'(lead) + 4'd8;
		end
	end

	smqr_tx u_tx (
		.clk       (clk),
		.arst_n    (arst_n),
		.ld_valid  (v_s3),
		.ld_reply  (reply),
		.ld_free   (ld_free),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.tx_byte   (tx_byte),
		.last      (last)
	);

	a_no_stall_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s1 |-> !in_stall)
		else $error("input stalled with first stage empty");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= smqr_pkg::CNT_W'(smqr_pkg::CMD_LEN))
		else $error("command count past line length");

	a_cr_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && is_cr) |=> (count_q == '0) && (letter_q == '0))
		else $error("carriage return did not clear the line");

endmodule
